### hdl/mask_shift_pixel_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mask/shift pixel converter
// ----------------------------------------------------------------------------
`ifndef MASK_SHIFT_PIXEL_CONVERTER_ASSERT_SVH
`define MASK_SHIFT_PIXEL_CONVERTER_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define MSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("msp assertion failed");

// consequent must hold in the same cycle as the antecedent
`define MSP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("msp assertion failed");

`endif

### hdl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and helper functions of the mask/shift pixel converter.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_CH         = 4;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_INDEX = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_RSVD  = 2'd3
    } req_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SRC_RED   = 3'd0,
        CFG_SRC_GREEN = 3'd1,
        CFG_SRC_BLUE  = 3'd2,
        CFG_SRC_ALPHA = 3'd3,
        CFG_DST_RED   = 3'd4,
        CFG_DST_GREEN = 3'd5,
        CFG_DST_BLUE  = 3'd6,
        CFG_DST_ALPHA = 3'd7
    } cfg_idx_t;

    // channel shift: signed, range -7..24
    typedef logic [5:0] shift_t;
    // channel move: signed, range -31..31
    typedef logic signed [6:0] delta_t;

    typedef struct packed {
        logic [NUM_CH-1:0][31:0] src_mask;
        logic [NUM_CH-1:0][31:0] dst_mask;
        logic [NUM_CH-1:0][5:0]  src_shift;
        logic [NUM_CH-1:0][5:0]  dst_shift;
    } cfg_t;

    localparam logic [NUM_CH-1:0][31:0] RST_MASK =
        {32'hFF00_0000, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};
    localparam logic [NUM_CH-1:0][5:0] RST_SHIFT = {6'd24, 6'd0, 6'd8, 6'd16};

    // Shift of a mask = (trailing zeros + run length) - 8, i.e. the position
    // of the first zero above the lowest run of ones, minus 8.
    function automatic shift_t mask_shift(input logic [31:0] m);
        logic [31:0] low;
        logic [32:0] x;
        logic [32:0] e;
        logic [5:0]  pos;
        low = m & (~m + 32'd1);
        x   = {1'b0, m} + {1'b0, low};
        e   = x & (~x + 33'd1);
        pos = '0;
        for (int i = 0; i < 33; i++) begin
            if (e[i]) begin
                pos = pos | 6'(i);
            end
        end
        if (m == '0) begin
            return '0;
        end
        return pos - 6'd8;
    endfunction

    // move left for positive d, right for negative, zero at 32 or more places
    function automatic logic [31:0] move_bits(input logic [31:0] v, input delta_t d);
        logic [6:0] mag;
        mag = '0;
        if (!d[6]) begin
            if (d[5]) begin
                return '0;
            end
            return v << d[4:0];
        end
        mag = 7'(-d);
        if (mag[6] || mag[5]) begin
            return '0;
        end
        return v >> mag[4:0];
    endfunction

endpackage

### hdl/msp_cfg.sv
// ----------------------------------------------------------------------------
// msp_cfg
// Channel mask registers; each channel's shift is worked out and stored
// together with its mask on the write.
// ----------------------------------------------------------------------------
module msp_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [msp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                         cfg_wdata,
    output msp_pkg::cfg_t                       cfg
);

    msp_pkg::cfg_t   cfg_reg;
    msp_pkg::shift_t wr_shift;

    assign wr_shift = msp_pkg::mask_shift(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_mask  <= msp_pkg::RST_MASK;
            cfg_reg.dst_mask  <= msp_pkg::RST_MASK;
            cfg_reg.src_shift <= msp_pkg::RST_SHIFT;
            cfg_reg.dst_shift <= msp_pkg::RST_SHIFT;
        end else if (cfg_wr_en) begin
            unique case (msp_pkg::cfg_idx_t'(cfg_index))
                msp_pkg::CFG_SRC_RED: begin
                    cfg_reg.src_mask[msp_pkg::CH_RED]  <= cfg_wdata;
                    cfg_reg.src_shift[msp_pkg::CH_RED] <= wr_shift;
                end
                msp_pkg::CFG_SRC_GREEN: begin
                    cfg_reg.src_mask[msp_pkg::CH_GREEN]  <= cfg_wdata;
                    cfg_reg.src_shift[msp_pkg::CH_GREEN] <= wr_shift;
                end
                msp_pkg::CFG_SRC_BLUE: begin
                    cfg_reg.src_mask[msp_pkg::CH_BLUE]  <= cfg_wdata;
                    cfg_reg.src_shift[msp_pkg::CH_BLUE] <= wr_shift;
                end
                msp_pkg::CFG_SRC_ALPHA: begin
                    cfg_reg.src_mask[msp_pkg::CH_ALPHA]  <= cfg_wdata;
                    cfg_reg.src_shift[msp_pkg::CH_ALPHA] <= wr_shift;
                end
                msp_pkg::CFG_DST_RED: begin
                    cfg_reg.dst_mask[msp_pkg::CH_RED]  <= cfg_wdata;
                    cfg_reg.dst_shift[msp_pkg::CH_RED] <= wr_shift;
                end
                msp_pkg::CFG_DST_GREEN: begin
                    cfg_reg.dst_mask[msp_pkg::CH_GREEN]  <= cfg_wdata;
                    cfg_reg.dst_shift[msp_pkg::CH_GREEN] <= wr_shift;
                end
                msp_pkg::CFG_DST_BLUE: begin
                    cfg_reg.dst_mask[msp_pkg::CH_BLUE]  <= cfg_wdata;
                    cfg_reg.dst_shift[msp_pkg::CH_BLUE] <= wr_shift;
                end
                msp_pkg::CFG_DST_ALPHA: begin
                    cfg_reg.dst_mask[msp_pkg::CH_ALPHA]  <= cfg_wdata;
                    cfg_reg.dst_shift[msp_pkg::CH_ALPHA] <= wr_shift;
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/msp_palette.sv
// ----------------------------------------------------------------------------
// msp_palette
// RGB palette memory, one write and one registered read per cycle, on a shared address.
// ----------------------------------------------------------------------------
module msp_palette #(
    parameter int INDEX_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic                  rd_en,
    input  logic [INDEX_BITS-1:0] addr,
    input  logic [23:0]           wr_data,
    output logic [23:0]           rd_data
);

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/msp_convert.sv
// ----------------------------------------------------------------------------
// msp_convert
// Per-channel move and mask of one pixel or palette entry into the target
// format; a pixel whose source and target masks match passes through whole.
// ----------------------------------------------------------------------------
module msp_convert (
    input  msp_pkg::cfg_t cfg,
    input  logic          is_index,
    input  logic [31:0]   pixel,
    input  logic [23:0]   entry,
    output logic [31:0]   result
);

    logic [msp_pkg::NUM_CH-1:0][31:0] pix_val;
    logic [msp_pkg::NUM_CH-1:0][31:0] idx_val;
    logic [msp_pkg::NUM_CH-1:0][31:0] ch_val;
    logic [msp_pkg::NUM_CH-1:0][5:0]  src_sh;
    msp_pkg::delta_t                  delta [msp_pkg::NUM_CH];
    logic [31:0]                      packed_px;
    logic                             same_fmt;

    assign same_fmt = (cfg.src_mask == cfg.dst_mask);

    always_comb begin
        for (int ch = 0; ch < msp_pkg::NUM_CH; ch++) begin
            pix_val[ch] = pixel & cfg.src_mask[ch];
        end
        // no source alpha: treat as fully opaque
        if (cfg.src_mask[msp_pkg::CH_ALPHA] == '0) begin
            pix_val[msp_pkg::CH_ALPHA] = msp_pkg::ALL_ONES;
        end
        idx_val[msp_pkg::CH_RED]   = {24'd0, entry[23:16]};
        idx_val[msp_pkg::CH_GREEN] = {24'd0, entry[15:8]};
        idx_val[msp_pkg::CH_BLUE]  = {24'd0, entry[7:0]};
        idx_val[msp_pkg::CH_ALPHA] = msp_pkg::ALL_ONES;

        packed_px = '0;
        for (int ch = 0; ch < msp_pkg::NUM_CH; ch++) begin
            ch_val[ch] = is_index ? idx_val[ch] : pix_val[ch];
            src_sh[ch] = is_index ? 6'd0 : cfg.src_shift[ch];
            delta[ch]  = $signed({cfg.dst_shift[ch][5], cfg.dst_shift[ch]})
                       - $signed({src_sh[ch][5], src_sh[ch]});
            packed_px  = packed_px
                       | (msp_pkg::move_bits(ch_val[ch], delta[ch]) & cfg.dst_mask[ch]);
        end
    end

    // identical formats pass the word through, bits outside the masks too
    assign result = (!is_index && same_fmt) ? pixel : packed_px;

endmodule

### hdl/mask_shift_pixel_converter.sv
// ----------------------------------------------------------------------------
// mask_shift_pixel_converter
// Packed RGBA format converter driven by channel masks, with an RGB palette
// for index conversion.
// ----------------------------------------------------------------------------
//  channel   ports                      payload
//  cfg       cfg_wr_en                  cfg_index, cfg_wdata (mask registers)
//  s_        s_valid / s_ready          request type, pixel, index, entry RGB
//  m_        m_valid / m_ready          converted pixel
//
//  One request per clock while s_ready is high. A pixel or index result is
//  offered from the result register: the input register and palette read
//  port load at the transfer, the result register when the output advances.
//  Palette writes and reserved requests give no result. A stalled output
//  holds the stage behind it; input stays ready while that stage is empty.
//  Reset clears the mask registers to 32-bit ARGB and empties the pipeline;
//  palette contents are undefined until written.
// ----------------------------------------------------------------------------
`include "mask_shift_pixel_converter_assert.svh"

module mask_shift_pixel_converter #(
    parameter int INDEX_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [msp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic [31:0]                         s_pixel_word,
    input  logic [7:0]                          s_palette_index,
    input  logic [7:0]                          s_entry_red,
    input  logic [7:0]                          s_entry_green,
    input  logic [7:0]                          s_entry_blue,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [31:0]                         m_out_pixel
);

    msp_pkg::cfg_t         cfg;
    logic                  s_accept;
    logic                  out_adv;
    logic                  take_item;
    logic                  take_index;
    logic                  pal_we;
    logic [INDEX_BITS-1:0] pal_addr;
    logic [23:0]           pal_rdata;
    logic [31:0]           conv_result;

    logic                  s1_valid_reg;
    logic                  s1_is_index_reg;
    logic [31:0]           s1_pixel_reg;
    logic                  m_valid_reg;
    logic [31:0]           m_pixel_reg;

    assign out_adv  = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_adv;
    assign s_accept = s_valid && s_ready;
    assign pal_addr = INDEX_BITS'(s_palette_index);

    always_comb begin
        take_item  = 1'b0;
        take_index = 1'b0;
        pal_we     = 1'b0;
        unique case (msp_pkg::req_t'(s_req_type))
            msp_pkg::REQ_PIXEL: begin
                take_item = 1'b1;
            end
            msp_pkg::REQ_INDEX: begin
                take_item  = 1'b1;
                take_index = 1'b1;
            end
            msp_pkg::REQ_WRITE: begin
                pal_we = s_accept;
            end
            msp_pkg::REQ_RSVD: begin
            end
            default: begin
            end
        endcase
    end

    msp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    msp_palette #(
        .INDEX_BITS (INDEX_BITS)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_we),
        .rd_en   (s_accept),
        .addr    (pal_addr),
        .wr_data ({s_entry_red, s_entry_green, s_entry_blue}),
        .rd_data (pal_rdata)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_accept && take_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_is_index_reg <= take_index;
            s1_pixel_reg    <= s_pixel_word;
        end
    end

    msp_convert u_convert (
        .cfg      (cfg),
        .is_index (s1_is_index_reg),
        .pixel    (s1_pixel_reg),
        .entry    (pal_rdata),
        .result   (conv_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            m_pixel_reg <= conv_result;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_pixel = m_pixel_reg;

    `MSP_ASSERT_NEXT(a_write_no_result, aclk, aresetn, s_accept && !take_item, !s1_valid_reg)
    `MSP_ASSERT_NEXT(a_stage_moves_out, aclk, aresetn, s1_valid_reg && out_adv, m_valid_reg)
    `MSP_ASSERT_NEXT(a_stage_holds, aclk, aresetn, s1_valid_reg && !out_adv, s1_valid_reg && $stable(s1_pixel_reg))
    `MSP_ASSERT_SAME(a_full_blocks_input, aclk, aresetn, m_valid_reg && !m_ready && s1_valid_reg, !s_ready)

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: mask/shift pixel converter testbench
// Sends pixel conversions, palette index conversions, palette writes and
// reserved requests under several mask formats. Random sender gaps and
// receiver stalls are applied. Each output pixel is checked against a
// local model of the channel shifts and the palette.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 70;
    localparam int NUM_PHASES   = 8;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [31:0] s_pixel_word;
    logic [7:0]  s_palette_index;
    logic [7:0]  s_entry_red;
    logic [7:0]  s_entry_green;
    logic [7:0]  s_entry_blue;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_out_pixel;

    // model state: format masks and palette
    logic [31:0] src_mask [4];
    logic [31:0] dst_mask [4];
    logic [23:0] palette_model [256];
    bit          palette_written [256];
    int          written_idx_q [$];

    logic [31:0] pixel_expect_q [$];
    logic [31:0] expected_pixel;
    int          fail_count;
    int          stall_count = 0;
    int          burst_left;
    bit          hold_req;
    int          rx_cycle;
    int          rx_mode;

    mask_shift_pixel_converter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_pixel_word    (s_pixel_word),
        .s_palette_index (s_palette_index),
        .s_entry_red     (s_entry_red),
        .s_entry_green   (s_entry_green),
        .s_entry_blue    (s_entry_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_pixel     (m_out_pixel)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Pixel model
    // ------------------------------------------------------------------
    function automatic int chan_shift(input logic [31:0] m);
        int          tz;
        int          run;
        logic [31:0] w;
        tz  = 0;
        run = 0;
        w   = m;
        if (m == '0) begin
            return 0;
        end
        while (w[0] == 1'b0) begin
            w = w >> 1;
            tz++;
        end
        // only the lowest run of ones counts
        while (w[0] == 1'b1) begin
            w = w >> 1;
            run++;
        end
        return tz - (8 - run);
    endfunction

    function automatic logic [31:0] shift_field(input logic [31:0] v, input int d);
        if (d >= 32 || d <= -32) begin
            return '0;
        end
        if (d >= 0) begin
            return v << d;
        end
        return v >> (-d);
    endfunction

    function automatic logic [31:0] convert_pixel(input logic [31:0] pix);
        logic [31:0] result;
        logic [31:0] chv;
        result = '0;
        if (src_mask[msp_pkg::CH_RED] == dst_mask[msp_pkg::CH_RED] &&
            src_mask[msp_pkg::CH_GREEN] == dst_mask[msp_pkg::CH_GREEN] &&
            src_mask[msp_pkg::CH_BLUE] == dst_mask[msp_pkg::CH_BLUE] &&
            src_mask[msp_pkg::CH_ALPHA] == dst_mask[msp_pkg::CH_ALPHA]) begin
            return pix;
        end
        for (int ch = 0; ch < msp_pkg::NUM_CH; ch++) begin
            if (ch == msp_pkg::CH_ALPHA && src_mask[ch] == '0) begin
                chv = msp_pkg::ALL_ONES;
            end else begin
                chv = pix & src_mask[ch];
            end
            result |= shift_field(chv, chan_shift(dst_mask[ch]) - chan_shift(src_mask[ch]))
                      & dst_mask[ch];
        end
        return result;
    endfunction

    function automatic logic [31:0] convert_index(input logic [7:0] idx);
        logic [31:0] result;
        logic [31:0] chv;
        logic [23:0] entry;
        result = '0;
        entry  = palette_model[idx];
        for (int ch = 0; ch < msp_pkg::NUM_CH; ch++) begin
            case (ch)
                msp_pkg::CH_RED:   chv = {24'd0, entry[23:16]};
                msp_pkg::CH_GREEN: chv = {24'd0, entry[15:8]};
                msp_pkg::CH_BLUE:  chv = {24'd0, entry[7:0]};
                default:           chv = msp_pkg::ALL_ONES;
            endcase
            result |= shift_field(chv, chan_shift(dst_mask[ch])) & dst_mask[ch];
        end
        return result;
    endfunction

    task automatic model_request(input msp_pkg::req_t kind, input logic [31:0] pix,
                                 input logic [7:0] idx, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
        case (kind)
            msp_pkg::REQ_PIXEL: pixel_expect_q.push_back(convert_pixel(pix));
            msp_pkg::REQ_INDEX: pixel_expect_q.push_back(convert_index(idx));
            msp_pkg::REQ_WRITE: begin
                palette_model[idx] = {r, g, b};
                if (!palette_written[idx]) begin
                    palette_written[idx] = 1'b1;
                    written_idx_q.push_back(idx);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_request(input msp_pkg::req_t kind, input logic [31:0] pix,
                                input logic [7:0] idx, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b);
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_req_type      <= kind;
        s_pixel_word    <= pix;
        s_palette_index <= idx;
        s_entry_red     <= r;
        s_entry_green   <= g;
        s_entry_blue    <= b;
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        model_request(kind, pix, idx, r, g, b);
    endtask

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // bursts of random length separated by random gaps
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_sender($urandom_range(1, 10));
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // wait for every outstanding result, plus slack for trailing writes
    task automatic drain_pipeline();
        idle_sender(1);
        while (pixel_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mask(input msp_pkg::cfg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            msp_pkg::CFG_SRC_RED:   src_mask[msp_pkg::CH_RED]   = val;
            msp_pkg::CFG_SRC_GREEN: src_mask[msp_pkg::CH_GREEN] = val;
            msp_pkg::CFG_SRC_BLUE:  src_mask[msp_pkg::CH_BLUE]  = val;
            msp_pkg::CFG_SRC_ALPHA: src_mask[msp_pkg::CH_ALPHA] = val;
            msp_pkg::CFG_DST_RED:   dst_mask[msp_pkg::CH_RED]   = val;
            msp_pkg::CFG_DST_GREEN: dst_mask[msp_pkg::CH_GREEN] = val;
            msp_pkg::CFG_DST_BLUE:  dst_mask[msp_pkg::CH_BLUE]  = val;
            default:                dst_mask[msp_pkg::CH_ALPHA] = val;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_format(input logic [31:0] sr, input logic [31:0] sg,
                              input logic [31:0] sb, input logic [31:0] sa,
                              input logic [31:0] dr, input logic [31:0] dg,
                              input logic [31:0] db, input logic [31:0] da);
        write_mask(msp_pkg::CFG_SRC_RED, sr);
        write_mask(msp_pkg::CFG_SRC_GREEN, sg);
        write_mask(msp_pkg::CFG_SRC_BLUE, sb);
        write_mask(msp_pkg::CFG_SRC_ALPHA, sa);
        write_mask(msp_pkg::CFG_DST_RED, dr);
        write_mask(msp_pkg::CFG_DST_GREEN, dg);
        write_mask(msp_pkg::CFG_DST_BLUE, db);
        write_mask(msp_pkg::CFG_DST_ALPHA, da);
    endtask

    // common packed formats, lanes {alpha, blue, green, red}
    function automatic logic [31:0] std_mask(input int fmt, input int ch);
        logic [127:0] lanes;
        case (fmt)
            0:       lanes = {32'hFF00_0000, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};
            1:       lanes = {32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF};
            2:       lanes = {32'h0000_0000, 32'h0000_001F, 32'h0000_07E0, 32'h0000_F800};
            3:       lanes = {32'h0000_8000, 32'h0000_001F, 32'h0000_03E0, 32'h0000_7C00};
            4:       lanes = {32'h0000_000F, 32'h0000_00F0, 32'h0000_0F00, 32'h0000_F000};
            default: lanes = {32'h0000_0000, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};
        endcase
        return lanes[ch*32 +: 32];
    endfunction

    function automatic logic [31:0] random_mask();
        logic [31:0] m;
        int          width;
        case ($urandom_range(0, 9))
            0: m = '0;
            1: m = msp_pkg::ALL_ONES;
            7: m = $urandom;
            8: m = 32'd1 << $urandom_range(0, 31);
            9: m = 32'hFF << (8 * $urandom_range(0, 3));
            default: begin
                width = $urandom_range(1, 12);
                m = msp_pkg::ALL_ONES >> (32 - width);
                m = m << $urandom_range(0, 32 - width);
            end
        endcase
        return m;
    endfunction

    task automatic choose_random_format();
        logic [31:0] sm [4];
        logic [31:0] dm [4];
        int          sfmt;
        int          dfmt;
        int          pick;
        sfmt = $urandom_range(0, 5);
        dfmt = $urandom_range(0, 5);
        pick = $urandom_range(0, 3);
        for (int ch = 0; ch < msp_pkg::NUM_CH; ch++) begin
            sm[ch] = $urandom_range(0, 1) ? std_mask(sfmt, ch) : random_mask();
        end
        for (int ch = 0; ch < msp_pkg::NUM_CH; ch++) begin
            case (pick)
                0:       dm[ch] = sm[ch];  // identical masks: passthrough
                1:       dm[ch] = std_mask(dfmt, ch);
                default: dm[ch] = random_mask();
            endcase
        end
        set_format(sm[msp_pkg::CH_RED], sm[msp_pkg::CH_GREEN],
                   sm[msp_pkg::CH_BLUE], sm[msp_pkg::CH_ALPHA],
                   dm[msp_pkg::CH_RED], dm[msp_pkg::CH_GREEN],
                   dm[msp_pkg::CH_BLUE], dm[msp_pkg::CH_ALPHA]);
    endtask

    // one random request; reserved requests are not counted
    task automatic random_request(output bit counted);
        int          p;
        logic [31:0] pix;
        logic [7:0]  idx;
        p   = $urandom_range(0, 99);
        pix = $urandom;
        idx = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0) begin
            pix = $urandom_range(0, 1) ? msp_pkg::ALL_ONES : '0;
        end
        counted = 1'b1;
        if (p < 55) begin
            send_request(msp_pkg::REQ_PIXEL, pix, idx, $urandom, $urandom, $urandom);
        end else if (p < 75 && written_idx_q.size() != 0) begin
            idx = written_idx_q[$urandom_range(0, written_idx_q.size() - 1)];
            send_request(msp_pkg::REQ_INDEX, pix, idx, $urandom, $urandom, $urandom);
        end else if (p < 95) begin
            send_request(msp_pkg::REQ_WRITE, pix, idx, $urandom, $urandom, $urandom);
        end else begin
            send_request(msp_pkg::REQ_RSVD, pix, idx, $urandom, $urandom, $urandom);
            counted = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_passthrough();
        send_request(msp_pkg::REQ_PIXEL, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(msp_pkg::REQ_PIXEL, msp_pkg::ALL_ONES, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(msp_pkg::REQ_RSVD, 32'h1234_5678, 8'hA5, 8'h5A, 8'hC3, 8'h3C);
        send_request(msp_pkg::REQ_PIXEL, 32'h1234_5678, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
    endtask

    task automatic test_palette();
        send_request(msp_pkg::REQ_WRITE, '0, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_request(msp_pkg::REQ_WRITE, '0, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_request(msp_pkg::REQ_WRITE, '0, 8'h5A, 8'hA5, 8'h5A, 8'hC3);
        // read straight after write to catch forwarding gaps
        send_request(msp_pkg::REQ_INDEX, msp_pkg::ALL_ONES, 8'h5A, 8'h00, 8'h00, 8'h00);
        send_request(msp_pkg::REQ_INDEX, '0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(msp_pkg::REQ_INDEX, '0, 8'hFF, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_format_edges();
        // ARGB8888 to RGB565, alpha dropped
        drain_pipeline();
        set_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000,
                   32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0000_0000);
        send_request(msp_pkg::REQ_PIXEL, msp_pkg::ALL_ONES, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(msp_pkg::REQ_PIXEL, 32'h80C0_E0F0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(msp_pkg::REQ_INDEX, '0, 8'h5A, 8'h00, 8'h00, 8'h00);
        // source without alpha gives opaque target alpha
        drain_pipeline();
        set_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'h0000_0000,
                   32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000);
        send_request(msp_pkg::REQ_PIXEL, 32'h0012_3456, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(msp_pkg::REQ_PIXEL, 32'hFF00_0000, 8'h00, 8'h00, 8'h00, 8'h00);
        // all-ones sources, all-zero targets
        drain_pipeline();
        set_format(msp_pkg::ALL_ONES, msp_pkg::ALL_ONES, msp_pkg::ALL_ONES,
                   msp_pkg::ALL_ONES, '0, '0, '0, '0);
        send_request(msp_pkg::REQ_PIXEL, msp_pkg::ALL_ONES, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(msp_pkg::REQ_INDEX, msp_pkg::ALL_ONES, 8'hFF, 8'h00, 8'h00, 8'h00);
        // widest moves, split mask, zero mask
        drain_pipeline();
        set_format(32'h0000_0001, 32'h8000_0001, 32'h0000_0000, msp_pkg::ALL_ONES,
                   32'h8000_0000, 32'h0000_0000, msp_pkg::ALL_ONES, 32'h0000_0001);
        send_request(msp_pkg::REQ_PIXEL, msp_pkg::ALL_ONES, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(msp_pkg::REQ_PIXEL, 32'h8000_0001, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        bit counted;
        drain_pipeline();
        set_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0000_0000,
                   32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000);
        hold_req = 1'b1;
        repeat (40) random_request(counted);
        wait (hold_req == 1'b0);
        drain_pipeline();
    endtask

    // each phase starts from an empty pipeline with a fresh format
    task automatic test_random_formats();
        int sent;
        bit counted;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_pipeline();
            choose_random_format();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                random_request(counted);
                if (counted) begin
                    sent++;
                end
                pace();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern and long hold-off
    // ------------------------------------------------------------------
    initial begin
        m_ready  = 1'b0;
        rx_cycle = 0;
        rx_mode  = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                rx_cycle++;
                if (rx_cycle % 97 == 0) begin
                    rx_mode = $urandom_range(0, 2);
                end
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ((rx_cycle % 7) < 4);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pixel_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result transfer: %h", m_out_pixel);
                end
            end else begin
                expected_pixel = pixel_expect_q.pop_front();
                if (m_out_pixel !== expected_pixel) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("out_pixel mismatch: expected %h actual %h",
                                 expected_pixel, m_out_pixel);
                    end
                end
            end
        end
    end

    // no transfer on either side for too long means a hang
    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = msp_pkg::CFG_SRC_RED;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_req_type      = msp_pkg::REQ_PIXEL;
        s_pixel_word    = '0;
        s_palette_index = '0;
        s_entry_red     = '0;
        s_entry_green   = '0;
        s_entry_blue    = '0;
        fail_count      = 0;
        burst_left      = 0;
        hold_req        = 1'b0;
        for (int ch = 0; ch < msp_pkg::NUM_CH; ch++) begin
            src_mask[ch] = std_mask(0, ch);
            dst_mask[ch] = std_mask(0, ch);
        end
        for (int i = 0; i < 256; i++) begin
            palette_model[i]   = '0;
            palette_written[i] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_passthrough();
        test_palette();
        test_format_edges();
        test_backpressure();
        test_random_formats();

        drain_pipeline();
        repeat (8) @(posedge aclk);
        fail_count += pixel_expect_q.size();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/msp_pkg.sv
hdl/msp_cfg.sv
hdl/msp_palette.sv
hdl/msp_convert.sv
hdl/mask_shift_pixel_converter.sv
test/tb.sv
